@@ hw/rtl/icmp_pkg.sv @@
// Shared types and constants for the interval comparison unit.
package icmp_pkg;

  typedef struct packed {
    logic signed [31:0] a_mon_count;
    logic signed [31:0] a_days;
    logic signed [63:0] a_offset_ns;
    logic signed [31:0] b_mon_count;
    logic signed [31:0] b_days;
    logic signed [63:0] b_offset_ns;
  } icmp_in_t;

  typedef struct packed {
    logic is_less;
    logic is_equal;
  } icmp_out_t;

  localparam int PIPE_STAGES = 6;

  // offset mod 125 from byte residues; top byte is biased by 128, hence the constant
  localparam int MOD_W = 17;
  localparam logic [6:0] RES_WT [8] = '{7'd1, 7'd6, 7'd36, 7'd91, 7'd46, 7'd26, 7'd31, 7'd61};
  localparam logic [MOD_W-1:0] RES_BIAS = 17'd192;
  localparam logic [6:0] RES_MOD = 7'd125;

  // floor(s / 125) = (s * RECIP) >> RECIP_SH for s < 2**MOD_W
  localparam int RECIP_W = 19;
  localparam logic [RECIP_W-1:0] RECIP = 19'd268436;
  localparam int RECIP_SH = 25;
  localparam int Q_W = 10;

  localparam logic [9:0] HALF_US_NS = 10'd500;
  localparam logic [9:0] NS_PER_US = 10'd1000;

  // ns per month = K_MON << MON_SH, ns per day = K_DAY << DAY_SH
  localparam logic [34:0] K_MON = 35'd19775390625;
  localparam int K_LO_W = 18;
  localparam logic [K_LO_W-1:0] K_MON_LO = K_MON[K_LO_W-1:0];
  localparam logic [16:0] K_MON_HI = K_MON[34:K_LO_W];
  localparam int MON_SH = 17;
  localparam logic [30:0] K_DAY = 31'd1318359375;
  localparam int DAY_SH = 16;

  localparam int MON_W = 67;
  localparam int DAYP_W = 63;
  localparam int RND_W = 66;
  localparam int TOT_W = 86;

endpackage

@@ hw/rtl/icmp_total.sv @@
// Pipelined reduction of one interval to its total in rounded nanoseconds.
module icmp_total
  import icmp_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [31:0]      months,
  input  logic signed [31:0]      days,
  input  logic signed [63:0]      offset_ns,
  output logic signed [TOT_W-1:0] total
);

  // stage B: residue sum and partial products
  logic signed [63:0]        x_b_r;
  logic [MOD_W-1:0]          sres_b_r, sres_b_nxt;
  logic signed [50:0]        mlo_b_r, mlo_b_nxt;
  logic signed [48:0]        mhi_b_r, mhi_b_nxt;
  logic signed [DAYP_W-1:0]  dp_b_r, dp_b_nxt;

  always_comb begin
    logic [7:0] byt;
    sres_b_nxt = RES_BIAS;
    for (int k = 0; k < 8; k++) begin
      byt = offset_ns[8*k +: 8];
      if (k == 7) begin
        byt = byt ^ 8'h80;
      end
      sres_b_nxt = sres_b_nxt + MOD_W'(byt) * MOD_W'(RES_WT[k]);
    end
    mlo_b_nxt = 51'(months) * 51'($signed({1'b0, K_MON_LO}));
    mhi_b_nxt = 49'(months) * 49'($signed({1'b0, K_MON_HI}));
    dp_b_nxt  = DAYP_W'(days) * DAYP_W'($signed({1'b0, K_DAY}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_b_r    <= offset_ns;
      sres_b_r <= sres_b_nxt;
      mlo_b_r  <= mlo_b_nxt;
      mhi_b_r  <= mhi_b_nxt;
      dp_b_r   <= dp_b_nxt;
    end
  end

  // stage C: quotient by 125, month product combined
  logic signed [63:0]        x_c_r;
  logic [MOD_W-1:0]          sres_c_r;
  logic [Q_W-1:0]            q_c_r, q_c_nxt;
  logic signed [MON_W-1:0]   mon_c_r, mon_c_nxt;
  logic signed [DAYP_W-1:0]  dp_c_r;
  logic [MOD_W+RECIP_W-1:0]  qprod;

  always_comb begin
    qprod     = (MOD_W+RECIP_W)'(sres_b_r) * (MOD_W+RECIP_W)'(RECIP);
    q_c_nxt   = qprod[RECIP_SH +: Q_W];
    mon_c_nxt = (MON_W'(mhi_b_r) <<< K_LO_W) + MON_W'(mlo_b_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_c_r    <= x_b_r;
      sres_c_r <= sres_b_r;
      q_c_r    <= q_c_nxt;
      mon_c_r  <= mon_c_nxt;
      dp_c_r   <= dp_b_r;
    end
  end

  // stage D: floor remainder mod 1000 via mod 8 and mod 125
  logic signed [63:0]        x_d_r;
  logic [9:0]                r_d_r, r_d_nxt;
  logic signed [MON_W-1:0]   mon_d_r;
  logic signed [DAYP_W-1:0]  dp_d_r;
  logic [MOD_W-1:0]          rem_full;
  logic [6:0]                r125;
  logic [2:0]                lift;

  always_comb begin
    rem_full = sres_c_r - MOD_W'(q_c_r) * MOD_W'(RES_MOD);
    r125     = rem_full[6:0];
    lift     = 3'(3'd5 * (x_c_r[2:0] - r125[2:0]));
    r_d_nxt  = 10'(r125) + 10'(lift) * 10'(RES_MOD);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_d_r   <= x_c_r;
      r_d_r   <= r_d_nxt;
      mon_d_r <= mon_c_r;
      dp_d_r  <= dp_c_r;
    end
  end

  // stage E: round half to even, scale months and days
  logic signed [RND_W-1:0]   rnd_e_r, rnd_e_nxt;
  logic signed [TOT_W-1:0]   part_e_r, part_e_nxt;
  logic [9:0]                low_diff;
  logic                      round_up;

  always_comb begin
    low_diff   = x_d_r[9:0] - r_d_r;
    round_up   = (r_d_r > HALF_US_NS) || ((r_d_r == HALF_US_NS) && low_diff[3]);
    rnd_e_nxt  = RND_W'(x_d_r) - RND_W'(r_d_r) + (round_up ? RND_W'(NS_PER_US) : '0);
    part_e_nxt = (TOT_W'(mon_d_r) <<< MON_SH) + (TOT_W'(dp_d_r) <<< DAY_SH);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_e_r  <= rnd_e_nxt;
      part_e_r <= part_e_nxt;
    end
  end

  // stage F: total
  logic signed [TOT_W-1:0] total_r, total_nxt;

  assign total_nxt = part_e_r + TOT_W'(rnd_e_r);

  always_ff @(posedge clk) begin
    if (en) begin
      total_r <= total_nxt;
    end
  end

  assign total = total_r;

endmodule

@@ hw/rtl/interval_compare_unit.sv @@
// Interval comparison unit: orders two (months, days, offset) intervals.
// Usage: present a pair of intervals on in_data with in_valid; the transaction
// is taken at a rising edge with in_valid high and in_stall low. Each result
// transaction carries is_less and is_equal on out_data, qualified by out_valid
// and taken when out_stall is low.
// Each interval is reduced to one total in rounded nanoseconds (months at 30
// days, offset rounded to microseconds, halves to even); equal totals mean
// identical normalised triples, so the totals are compared directly.
// Throughput: one transaction per cycle when not stalled; the pipeline is
// seven registers deep (input, five arithmetic stages, output) and advances
// as a whole.
// Stall: while out_valid is high and out_stall is high the whole pipeline
// holds and in_stall is raised; nothing is dropped.
// Reset: synchronous, active low; clears all valid flags, pipeline empty.
module interval_compare_unit
  import icmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  icmp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output icmp_out_t out_data
);

  logic                     adv;
  logic [PIPE_STAGES-1:0]   vld_r, vld_nxt;
  logic                     out_valid_r;
  icmp_in_t                 in_r;
  icmp_out_t                out_r, out_nxt;
  logic signed [TOT_W-1:0]  tot_a, tot_b;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign vld_nxt  = {vld_r[PIPE_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_data;
    end
  end

  icmp_total u_total_a (
    .clk       (clk),
    .en        (adv),
    .months    (in_r.a_mon_count),
    .days      (in_r.a_days),
    .offset_ns (in_r.a_offset_ns),
    .total     (tot_a)
  );

  icmp_total u_total_b (
    .clk       (clk),
    .en        (adv),
    .months    (in_r.b_mon_count),
    .days      (in_r.b_days),
    .offset_ns (in_r.b_offset_ns),
    .total     (tot_b)
  );

  always_comb begin
    out_nxt.is_less  = tot_a < tot_b;
    out_nxt.is_equal = tot_a == tot_b;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for interval_compare_unit: normalised interval ordering.
`timescale 1ns / 1ps

module tb_top
  import icmp_pkg::*;
();

  localparam longint NS_US     = 1000;
  localparam longint HALF_NS   = 500;
  localparam longint US_DAY    = 64'sd86400000000;
  localparam longint NS_DAY    = 64'sd86400000000000;
  localparam longint DAYS_MON  = 30;
  localparam longint I64_MIN   = 64'sh8000_0000_0000_0000;
  localparam longint I64_MAX   = 64'sh7fff_ffff_ffff_ffff;
  localparam int     I32_MIN   = 32'sh8000_0000;
  localparam int     I32_MAX   = 32'sh7fff_ffff;
  localparam int     N_RANDOM  = 1650;
  localparam int     MAX_CYCLES = 1000000;
  localparam int     MAX_SHOWN = 10;

  typedef struct {
    longint mon;
    longint day;
    longint us;
  } norm_ivl_t;

  class order_board;
    icmp_out_t pending[$];
    int errors;

    function longint round_to_us(longint ns);
      longint tr, rem, mag, away;
      tr = ns / NS_US;
      rem = ns - tr * NS_US;
      mag = (rem < 0) ? -rem : rem;
      if (mag < HALF_NS) return tr;
      away = tr + ((ns < 0) ? -64'sd1 : 64'sd1);
      if (mag > HALF_NS) return away;
      return away[0] ? tr : away;
    endfunction

    function norm_ivl_t normalise(longint mon, longint day, longint ns);
      norm_ivl_t r;
      longint us, cd;
      us = round_to_us(ns);
      cd = us / US_DAY;
      day = day + cd;
      us = us - cd * US_DAY;
      if (us < 0) begin
        us = us + US_DAY;
        day = day - 1;
      end
      mon = mon + day / DAYS_MON;
      day = day % DAYS_MON;
      if (day < 0) begin
        day = day + DAYS_MON;
        mon = mon - 1;
      end
      r.mon = mon;
      r.day = day;
      r.us = us;
      return r;
    endfunction

    function icmp_out_t order_of(icmp_in_t d);
      norm_ivl_t a, b;
      icmp_out_t r;
      a = normalise(longint'(signed'(d.a_mon_count)), longint'(signed'(d.a_days)),
                    longint'(signed'(d.a_offset_ns)));
      b = normalise(longint'(signed'(d.b_mon_count)), longint'(signed'(d.b_days)),
                    longint'(signed'(d.b_offset_ns)));
      if (a.mon != b.mon) begin
        r.is_less = a.mon < b.mon;
        r.is_equal = 1'b0;
      end else if (a.day != b.day) begin
        r.is_less = a.day < b.day;
        r.is_equal = 1'b0;
      end else begin
        r.is_less = a.us < b.us;
        r.is_equal = a.us == b.us;
      end
      return r;
    endfunction

    function void note_pair(icmp_in_t d);
      pending.push_back(order_of(d));
    endfunction

    function void check_result(icmp_out_t r);
      icmp_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: unexpected result less=%b equal=%b", $time, r.is_less, r.is_equal);
        return;
      end
      e = pending.pop_front();
      if (r.is_less !== e.is_less || r.is_equal !== e.is_equal) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: mismatch less exp %b got %b, equal exp %b got %b",
                   $time, e.is_less, r.is_less, e.is_equal, r.is_equal);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  icmp_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  icmp_out_t out_data;

  order_board sb = new();
  bit no_idle = 1'b0;
  int cycles = 0;
  int stall_left = 0;

  interval_compare_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pair(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 99) < 15) begin
      stall_left <= gap_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic icmp_in_t pair(int am, int ad, longint ao, int bm, int bd, longint bo);
    icmp_in_t d;
    d.a_mon_count = am;
    d.a_days = ad;
    d.a_offset_ns = ao;
    d.b_mon_count = bm;
    d.b_days = bd;
    d.b_offset_ns = bo;
    return d;
  endfunction

  function automatic int rnd_count();
    case ($urandom_range(0, 9))
      0, 1, 2: return int'($urandom_range(0, 200)) - 100;
      3, 4:    return int'($urandom());
      5: begin
        case ($urandom_range(0, 3))
          0: return I32_MIN;
          1: return I32_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, 200000)) - 100000;
    endcase
  endfunction

  function automatic longint rnd_ns();
    longint k;
    case ($urandom_range(0, 9))
      0, 1: return longint'($urandom_range(0, 2000000)) - 64'sd1000000;
      2, 3: return longint'(int'($urandom())) * 64'sd1000;
      4: begin
        k = longint'(int'($urandom())) * NS_US;
        return $urandom_range(0, 1) ? k + HALF_NS : k - HALF_NS;
      end
      5, 6: return {$urandom(), $urandom()};
      7: begin
        case ($urandom_range(0, 5))
          0: return I64_MIN;
          1: return I64_MAX;
          2: return I64_MIN + 1;
          3: return I64_MAX - 1;
          4: return 0;
          default: return -1;
        endcase
      end
      default: return longint'(int'($urandom())) * longint'($urandom_range(1, 4000000));
    endcase
  endfunction

  // b is an equivalent form of a, then possibly nudged by a small amount; a and b may then be swapped
  function automatic icmp_in_t rnd_twin();
    icmp_in_t d;
    int am, ad, k, j;
    longint ao, bo;
    am = int'($urandom_range(0, 2000000)) - 1000000;
    ad = int'($urandom_range(0, 2000000)) - 1000000;
    ao = longint'(int'($urandom())) * longint'($urandom_range(1, 1000));
    if ($urandom_range(0, 3) == 0) ao = (ao / NS_US) * NS_US + HALF_NS;
    k = int'($urandom_range(0, 2000)) - 1000;
    j = int'($urandom_range(0, 2000)) - 1000;
    bo = ao + longint'(j) * NS_DAY;
    d = pair(am, ad, ao, am - k, ad + 30 * k - j, bo);
    case ($urandom_range(0, 9))
      0: d.b_offset_ns = d.b_offset_ns + 1;
      1: d.b_offset_ns = d.b_offset_ns - 1;
      2: d.b_offset_ns = d.b_offset_ns + NS_US;
      3: d.b_offset_ns = d.b_offset_ns - NS_US;
      4: d.b_days = d.b_days + ($urandom_range(0, 1) ? 1 : -1);
      5: d.b_mon_count = d.b_mon_count + ($urandom_range(0, 1) ? 1 : -1);
      6: d.b_offset_ns = d.b_offset_ns + ($urandom_range(0, 1) ? HALF_NS : -HALF_NS);
      default: ;
    endcase
    if ($urandom_range(0, 1)) d = pair(d.b_mon_count, d.b_days, d.b_offset_ns,
                                       d.a_mon_count, d.a_days, d.a_offset_ns);
    return d;
  endfunction

  function automatic icmp_in_t rnd_pair();
    icmp_in_t d;
    case ($urandom_range(0, 9))
      0, 1, 2: return pair(rnd_count(), rnd_count(), rnd_ns(),
                           rnd_count(), rnd_count(), rnd_ns());
      3: begin
        d = pair(rnd_count(), rnd_count(), rnd_ns(), 0, 0, 0);
        d.b_mon_count = d.a_mon_count;
        d.b_days = d.a_days;
        d.b_offset_ns = $urandom_range(0, 1) ? rnd_ns() : d.a_offset_ns;
        return d;
      end
      default: return rnd_twin();
    endcase
  endfunction

  task automatic send_pair(input icmp_in_t d);
    in_data <= d;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if (!no_idle && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  icmp_in_t directed[$];

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    directed = {
      pair(0, 0, 0, 0, 0, 0),
      pair(0, 0, 500, 0, 0, 0),
      pair(0, 0, 1500, 0, 0, 2000),
      pair(0, 0, 2500, 0, 0, 2000),
      pair(0, 0, -500, 0, 0, 0),
      pair(0, 0, -1500, 0, 0, -2000),
      pair(0, 0, -2500, 0, 0, -2000),
      pair(0, 0, 501, 0, 0, 0),
      pair(0, 0, 0, 0, 0, 1499),
      pair(0, 0, -1, 0, 0, 499),
      pair(0, 1, 0, 0, 0, NS_DAY),
      pair(0, 0, -1000, 0, -1, NS_DAY - 1000),
      pair(1, 0, 0, 0, 30, 0),
      pair(0, -1, 0, -1, 29, 0),
      pair(I32_MAX, I32_MAX, I64_MAX, I32_MIN, I32_MIN, I64_MIN),
      pair(I32_MIN, I32_MIN, I64_MIN, I32_MAX, I32_MAX, I64_MAX),
      pair(I32_MAX, I32_MAX, I64_MAX, I32_MAX, I32_MAX, I64_MAX),
      pair(I32_MIN, I32_MIN, I64_MIN, I32_MIN, I32_MIN, I64_MIN),
      pair(0, 0, I64_MIN, 0, 0, I64_MAX),
      pair(0, 0, I64_MAX, 0, 0, I64_MIN),
      pair(-1, -1, -1, 0, 0, 0),
      pair(I32_MAX, 0, 0, 0, I32_MAX, 0),
      pair(0, I32_MIN, 0, I32_MIN, 0, 0)
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      send_pair(directed[i]);
      idle_gap();
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 1100 && i < 1300);
      if (i == 700) begin
        // hold off until the pipeline has fully drained
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0) @(negedge clk);
      end
      send_pair(rnd_pair());
      idle_gap();
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4 * PIPE_STAGES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ interval_compare_unit.f @@
hw/rtl/icmp_pkg.sv
hw/rtl/icmp_total.sv
hw/rtl/interval_compare_unit.sv
verif/tb_top.sv
